>>> hw/rtl/pccp_pkg.sv
// pccp_pkg: shared types and constants of the polygon cull, clip and project block
// used by pccp_div and polygon_cull_clip_project; no dependencies
package pccp_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int VAL_W      = 32;
    localparam int VEC_W      = 3 * VAL_W;
    localparam int COEF_SLOTS = 24;
    localparam int COEF_AW    = 5;

    // shared divider: wide dividend, 32-bit divisor
    localparam int DVD_W = 64;
    localparam int DVS_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PLANE  = 3'd4;

    localparam logic [28:0]        HALF_WIDTH_RST  = 29'd26214400;
    localparam logic [28:0]        HALF_HEIGHT_RST = 29'd19660800;
    localparam logic signed [29:0] OFFSET_X_RST    = 30'sd26214400;
    localparam logic signed [29:0] OFFSET_Y_RST    = 30'sd19660800;
    localparam logic [30:0]        NEAR_PLANE_RST  = 31'd66191;

    // input item codes
    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic done;
        logic busy;
    } t_div_stat;

endpackage

>>> hw/rtl/pccp_ram.sv
// pccp_ram: generic one-write, one-read RAM with registered read data
// depends on nothing
module pccp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pccp_div.sv
// pccp_div: restoring unsigned divider, one quotient bit per cycle
// depends on pccp_pkg (widths, t_div_stat)
module pccp_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pccp_pkg::DVD_W-1:0] i_dividend,
    input  logic [pccp_pkg::DVS_W-1:0] i_divisor,
    output logic [pccp_pkg::DVD_W-1:0] o_quotient,
    output pccp_pkg::t_div_stat        o_stat
);

    localparam int DVD_W = pccp_pkg::DVD_W;
    localparam int DVS_W = pccp_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W+1:0] trial;

    // shift in the next dividend bit and try the subtract
    assign trial = {1'b0, r_rem, r_dvd[DVD_W-1]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!trial[DVS_W+1]) begin
                    r_rem <= trial[DVS_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DVS_W-2:0], r_dvd[DVD_W-1]};
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_dvd;
    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;

endmodule

>>> hw/rtl/polygon_cull_clip_project.sv
// polygon_cull_clip_project: view transform, backface cull, near-plane clip and
// projection of one polygon; uses pccp_pkg, pccp_ram (tables) and pccp_div
//
//  channel   signals                                         direction
//  command   start, i_op, i_coef_index, i_coef_value,        in
//            i_pos_x, i_pos_y, i_pos_z, i_end_of_polygon     in; busy is out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                 in
//  result    o_valid, o_screen_x, o_screen_y,                out
//            o_point_index, o_last_point
//
// a coefficient beat writes the coefficient table; a vertex beat runs through the
// shared multiply-accumulate (12 terms plus saturation).
// closing a polygon adds the cull, two divides per clip crossing and two per
// emitted point; the shared divider sets most of that work.
// reset is synchronous, active low, and clears the sequencer, counts and config.
// results come as one-cycle strobes; the receiver cannot stall them.
module polygon_cull_clip_project #(
    parameter int MAX_VERTICES = pccp_pkg::MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = pccp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [pccp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pccp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_op,
    input  logic [4:0]                          i_coef_index,
    input  logic signed [31:0]                  i_coef_value,
    input  logic signed [31:0]                  i_pos_x,
    input  logic signed [31:0]                  i_pos_y,
    input  logic signed [31:0]                  i_pos_z,
    input  logic                                i_end_of_polygon,
    output logic                                o_valid,
    output logic signed [15:0]                  o_screen_x,
    output logic signed [15:0]                  o_screen_y,
    output logic [3:0]                          o_point_index,
    output logic                                o_last_point
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VEC_W = pccp_pkg::VEC_W;
    localparam logic MODE_XF   = 1'b0;
    localparam logic MODE_PROJ = 1'b1;
    localparam logic signed [32:0] ONE_Q     = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [66:0] PIX_ADJ   = (67'sd1 <<< FRAC_BITS) - 67'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_DADDR, S_DMUL, S_DACC, S_DDONE, S_DEND,
        S_CLOSE, S_CRD, S_CLD, S_CMUL, S_CACC, S_CDEC,
        S_LRDP, S_LLDP, S_LRDC, S_LLDC, S_EMUL, S_EDGO, S_EDWT, S_EFIN,
        S_PUSHC, S_LNXT,
        S_PRD, S_PLD, S_XMUL, S_XDGO, S_XDWT, S_XSUM, S_XPIX
    } t_state;

    function automatic logic signed [32:0] f_sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -68'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [4:0] f_coef_addr(input logic mode, input logic [1:0] k,
                                               input logic [1:0] t);
        logic [4:0] a;
        if (mode == MODE_PROJ) a = 5'd12 + {1'b0, k, 2'b00} + {3'b000, t};
        else if (t == 2'd3) a = 5'd9 + {3'b000, k};
        else a = {3'b000, k} + {3'b000, t} + {2'b00, t, 1'b0};
        return a;
    endfunction

    function automatic logic signed [31:0] f_pick(input logic signed [31:0] v0,
                                                  input logic signed [31:0] v1,
                                                  input logic signed [31:0] v2,
                                                  input logic [1:0] sel);
        logic signed [31:0] r;
        case (sel)
            2'd0:    r = v0;
            2'd1:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    // configuration
    logic [28:0]        r_half_w, r_half_h;
    logic signed [29:0] r_off_x, r_off_y;
    logic [30:0]        r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= pccp_pkg::HALF_WIDTH_RST;
            r_half_h <= pccp_pkg::HALF_HEIGHT_RST;
            r_off_x  <= pccp_pkg::OFFSET_X_RST;
            r_off_y  <= pccp_pkg::OFFSET_Y_RST;
            r_near   <= pccp_pkg::NEAR_PLANE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pccp_pkg::CFG_HALF_WIDTH:  r_half_w <= i_cfg_data[28:0];
                pccp_pkg::CFG_HALF_HEIGHT: r_half_h <= i_cfg_data[28:0];
                pccp_pkg::CFG_OFFSET_X:    r_off_x  <= i_cfg_data[29:0];
                pccp_pkg::CFG_OFFSET_Y:    r_off_y  <= i_cfg_data[29:0];
                pccp_pkg::CFG_NEAR_PLANE:  r_near   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state              r_state;
    logic                r_mode;
    logic                r_eop;
    logic [1:0]          r_t, r_k, r_step;
    logic                r_comp, r_cin, r_neg;
    logic [CNT_W-1:0]    r_cnt, r_n, r_i, r_m, r_j;
    logic signed [31:0]  r_opnd [3];
    logic signed [31:0]  r_res  [3];
    logic signed [31:0]  r_va [3];
    logic signed [31:0]  r_vb [3];
    logic signed [31:0]  r_vc [3];
    logic signed [31:0]  r_pv [3];
    logic signed [31:0]  r_cv [3];
    logic signed [31:0]  r_ex;
    logic signed [65:0]  r_prod;
    logic signed [67:0]  r_acc;
    logic signed [64:0]  r_cr;
    logic signed [99:0]  r_big;
    logic signed [66:0]  r_s;
    logic                r_o_valid, r_o_last;
    logic signed [15:0]  r_o_sx, r_o_sy;
    logic [3:0]          r_o_idx;

    // memories
    logic                coef_we;
    logic [4:0]          coef_raddr;
    logic [31:0]         coef_rdata;
    logic                view_we;
    logic [AW-1:0]       view_raddr;
    logic [VEC_W-1:0]    view_rdata, view_wdata;
    logic                clip_we;
    logic [VEC_W-1:0]    clip_rdata, clip_wdata;

    // shared divider
    logic                         div_start;
    logic [pccp_pkg::DVD_W-1:0]   div_dvd, div_q;
    logic [pccp_pkg::DVS_W-1:0]   div_dvs;
    pccp_pkg::t_div_stat          div_stat;

    // datapath
    logic                accept;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod_q;
    logic signed [31:0]  coef_rd;
    logic signed [31:0]  a_k, b_1, b_2, c_1, c_2;
    logic [1:0]          i1, i2;
    logic signed [32:0]  near_s, nmp, d_e, dz;
    logic [31:0]         mag_n, mag_d, den, q_e;
    logic signed [31:0]  p_e, c_e, edge_res;
    logic                cin_rd, pin;
    logic [CNT_W-1:0]    n_last;
    logic signed [31:0]  w_raw;
    logic [31:0]         w_div;
    logic signed [65:0]  prod_mag, q_s;
    logic signed [66:0]  s_next, pix_shift;
    logic signed [15:0]  pix;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign coef_we    = accept && (i_op == pccp_pkg::OP_COEF) &&
                        (i_coef_index < 5'(pccp_pkg::COEF_SLOTS));
    assign coef_raddr = f_coef_addr(r_mode, r_k, r_t);
    assign coef_rd    = coef_rdata;

    assign n_last = r_n - 1'b1;
    always_comb begin
        case (r_state)
            S_LRDP:  view_raddr = n_last[AW-1:0];
            default: view_raddr = r_i[AW-1:0];
        endcase
    end
    assign view_we    = (r_state == S_DEND) && (r_mode == MODE_XF);
    assign view_wdata = {r_res[2], r_res[1], r_res[0]};

    // cull operand selection: cr[k] = b[i1]*c[i2] - b[i2]*c[i1]
    assign i1  = (r_k == 2'd0) ? 2'd1 : ((r_k == 2'd1) ? 2'd2 : 2'd0);
    assign i2  = (r_k == 2'd0) ? 2'd2 : ((r_k == 2'd1) ? 2'd0 : 2'd1);
    assign a_k = f_pick(r_va[0], r_va[1], r_va[2], r_k);
    assign b_1 = f_pick(r_vb[0], r_vb[1], r_vb[2], i1);
    assign b_2 = f_pick(r_vb[0], r_vb[1], r_vb[2], i2);
    assign c_1 = f_pick(r_vc[0], r_vc[1], r_vc[2], i1);
    assign c_2 = f_pick(r_vc[0], r_vc[1], r_vc[2], i2);

    // edge crossing
    assign near_s   = {2'b00, r_near};
    assign p_e      = r_comp ? r_pv[1] : r_pv[0];
    assign c_e      = r_comp ? r_cv[1] : r_cv[0];
    assign nmp      = near_s - f_sx33(r_pv[2]);
    assign mag_n    = nmp[32] ? 32'(-nmp) : nmp[31:0];
    assign d_e      = f_sx33(c_e) - f_sx33(p_e);
    assign mag_d    = d_e[32] ? 32'(-d_e) : d_e[31:0];
    assign dz       = f_sx33(r_cv[2]) - f_sx33(r_pv[2]);
    assign den      = dz[32] ? 32'(-dz) : dz[31:0];
    assign q_e      = (den == '0) ? '0 : div_q[31:0];
    assign edge_res = d_e[32] ? (p_e - $signed(q_e)) : (p_e + $signed(q_e));
    assign cin_rd   = (f_sx33(view_rdata[95:64]) >= near_s);
    assign pin      = (f_sx33(r_pv[2]) >= near_s);

    assign clip_we    = ((r_state == S_EFIN) && r_comp) ||
                        ((r_state == S_PUSHC) && (r_m < CNT_W'(MAX_VERTICES)));
    assign clip_wdata = (r_state == S_EFIN) ? {{1'b0, r_near}, edge_res, r_ex}
                                            : {r_cv[2], r_cv[1], r_cv[0]};

    // projection to pixels
    assign w_raw     = r_res[2];
    assign w_div     = (w_raw < 32'sd1) ? 32'd1 : w_raw[31:0];
    assign prod_mag  = r_prod[65] ? -r_prod : r_prod;
    assign q_s       = r_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign s_next    = r_comp ? ({{37{r_off_y[29]}}, r_off_y} - {q_s[65], q_s})
                              : ({{37{r_off_x[29]}}, r_off_x} + {q_s[65], q_s});
    assign pix_shift = (r_s + (r_s[66] ? PIX_ADJ : 67'sd0)) >>> FRAC_BITS;
    assign pix       = (pix_shift > 67'sd32767)  ? 16'sh7FFF :
                       (pix_shift < -67'sd32768) ? 16'sh8000 : pix_shift[15:0];

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DMUL: begin
                mul_b = f_sx33(coef_rd);
                mul_a = (r_t == 2'd3) ? ONE_Q : f_sx33(f_pick(r_opnd[0], r_opnd[1],
                                                              r_opnd[2], r_t));
            end
            S_CMUL: begin
                case (r_step)
                    2'd0: begin
                        mul_a = f_sx33(b_1);
                        mul_b = f_sx33(c_2);
                    end
                    2'd1: begin
                        mul_a = f_sx33(b_2);
                        mul_b = f_sx33(c_1);
                    end
                    2'd2: begin
                        mul_a = {1'b0, r_cr[31:0]};
                        mul_b = f_sx33(a_k);
                    end
                    default: begin
                        mul_a = r_cr[64:32];
                        mul_b = f_sx33(a_k);
                    end
                endcase
            end
            S_EMUL: begin
                mul_a = {1'b0, mag_n};
                mul_b = {1'b0, mag_d};
            end
            S_XMUL: begin
                mul_a = f_sx33(r_comp ? r_res[1] : r_res[0]);
                mul_b = {4'b0000, (r_comp ? r_half_h : r_half_w)};
            end
            default: ;
        endcase
    end

    assign prod_q = r_prod >>> FRAC_BITS;

    assign div_start = (r_state == S_EDGO) || (r_state == S_XDGO);
    assign div_dvd   = (r_state == S_XDGO) ? prod_mag[63:0] : r_prod[63:0];
    assign div_dvs   = (r_state == S_XDGO) ? w_div : den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_prod    <= mul_a * mul_b;
            r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == pccp_pkg::OP_VERTEX)) begin
                        r_eop <= i_end_of_polygon;
                        if (r_cnt < CNT_W'(MAX_VERTICES)) begin
                            r_opnd[0] <= i_pos_x;
                            r_opnd[1] <= i_pos_y;
                            r_opnd[2] <= i_pos_z;
                            r_mode    <= MODE_XF;
                            r_k       <= '0;
                            r_t       <= '0;
                            r_acc     <= '0;
                            r_state   <= S_DADDR;
                        end else if (i_end_of_polygon) begin
                            r_state <= S_CLOSE;
                        end
                    end
                end
                // dot product: three terms and a constant per output
                S_DADDR: r_state <= S_DMUL;
                S_DMUL:  r_state <= S_DACC;
                S_DACC: begin
                    r_acc <= r_acc + {{2{prod_q[65]}}, prod_q};
                    if (r_t == 2'd3) begin
                        r_state <= S_DDONE;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_DADDR;
                    end
                end
                S_DDONE: begin
                    r_res[r_k] <= f_sat32(r_acc);
                    r_acc      <= '0;
                    r_t        <= '0;
                    if (r_k == 2'd2) begin
                        r_state <= S_DEND;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DADDR;
                    end
                end
                S_DEND: begin
                    if (r_mode == MODE_XF) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= r_eop ? S_CLOSE : S_IDLE;
                    end else begin
                        r_comp  <= 1'b0;
                        r_state <= S_XMUL;
                    end
                end
                S_CLOSE: begin
                    r_n   <= r_cnt;
                    r_cnt <= '0;
                    r_m   <= '0;
                    r_i   <= '0;
                    r_state <= (r_cnt < CNT_W'(3)) ? S_IDLE : S_CRD;
                end
                // backface test on the first three view vertices
                S_CRD: r_state <= S_CLD;
                S_CLD: begin
                    case (r_i[1:0])
                        2'd0: begin
                            r_va[0] <= view_rdata[31:0];
                            r_va[1] <= view_rdata[63:32];
                            r_va[2] <= view_rdata[95:64];
                        end
                        2'd1: begin
                            r_vb[0] <= view_rdata[31:0];
                            r_vb[1] <= view_rdata[63:32];
                            r_vb[2] <= view_rdata[95:64];
                        end
                        default: begin
                            r_vc[0] <= view_rdata[31:0];
                            r_vc[1] <= view_rdata[63:32];
                            r_vc[2] <= view_rdata[95:64];
                        end
                    endcase
                    if (r_i == CNT_W'(2)) begin
                        r_k     <= '0;
                        r_step  <= '0;
                        r_big   <= '0;
                        r_state <= S_CMUL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_CMUL: r_state <= S_CACC;
                S_CACC: begin
                    case (r_step)
                        2'd0:    r_cr  <= r_prod[64:0];
                        2'd1:    r_cr  <= r_cr - r_prod[64:0];
                        2'd2:    r_big <= r_big + {{34{r_prod[65]}}, r_prod};
                        default: r_big <= r_big + {{2{r_prod[65]}}, r_prod, 32'd0};
                    endcase
                    if (r_step == 2'd3) begin
                        r_step <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_CDEC;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CMUL;
                        end
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_CMUL;
                    end
                end
                S_CDEC: begin
                    r_state <= (r_big > 100'sd0) ? S_IDLE : S_LRDP;
                end
                // near-plane clip, previous vertex starts at the last one
                S_LRDP: r_state <= S_LLDP;
                S_LLDP: begin
                    r_pv[0] <= view_rdata[31:0];
                    r_pv[1] <= view_rdata[63:32];
                    r_pv[2] <= view_rdata[95:64];
                    r_i     <= '0;
                    r_state <= S_LRDC;
                end
                S_LRDC: r_state <= S_LLDC;
                S_LLDC: begin
                    r_cv[0] <= view_rdata[31:0];
                    r_cv[1] <= view_rdata[63:32];
                    r_cv[2] <= view_rdata[95:64];
                    r_cin   <= cin_rd;
                    r_comp  <= 1'b0;
                    if ((cin_rd != pin) && (r_m < CNT_W'(MAX_VERTICES))) begin
                        r_state <= S_EMUL;
                    end else begin
                        r_state <= cin_rd ? S_PUSHC : S_LNXT;
                    end
                end
                S_EMUL: r_state <= S_EDGO;
                S_EDGO: r_state <= S_EDWT;
                S_EDWT: begin
                    if (div_stat.done) begin
                        r_state <= S_EFIN;
                    end
                end
                S_EFIN: begin
                    if (!r_comp) begin
                        r_ex    <= edge_res;
                        r_comp  <= 1'b1;
                        r_state <= S_EMUL;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= r_cin ? S_PUSHC : S_LNXT;
                    end
                end
                S_PUSHC: begin
                    if (r_m < CNT_W'(MAX_VERTICES)) begin
                        r_m <= r_m + 1'b1;
                    end
                    r_state <= S_LNXT;
                end
                S_LNXT: begin
                    r_pv <= r_cv;
                    r_i  <= r_i + 1'b1;
                    if (r_i == n_last) begin
                        r_j     <= '0;
                        r_state <= (r_m < CNT_W'(3)) ? S_IDLE : S_PRD;
                    end else begin
                        r_state <= S_LRDC;
                    end
                end
                // projection of each kept point
                S_PRD: r_state <= S_PLD;
                S_PLD: begin
                    r_opnd[0] <= clip_rdata[31:0];
                    r_opnd[1] <= clip_rdata[63:32];
                    r_opnd[2] <= clip_rdata[95:64];
                    r_mode    <= MODE_PROJ;
                    r_k       <= '0;
                    r_t       <= '0;
                    r_acc     <= '0;
                    r_state   <= S_DADDR;
                end
                S_XMUL: r_state <= S_XDGO;
                S_XDGO: begin
                    r_neg   <= r_prod[65];
                    r_state <= S_XDWT;
                end
                S_XDWT: begin
                    if (div_stat.done) begin
                        r_state <= S_XSUM;
                    end
                end
                S_XSUM: begin
                    r_s     <= s_next;
                    r_state <= S_XPIX;
                end
                S_XPIX: begin
                    if (!r_comp) begin
                        r_o_sx  <= pix;
                        r_comp  <= 1'b1;
                        r_state <= S_XMUL;
                    end else begin
                        r_o_sy    <= pix;
                        r_o_valid <= 1'b1;
                        r_o_idx   <= r_j[3:0];
                        r_o_last  <= (r_j == r_m - 1'b1);
                        r_j       <= r_j + 1'b1;
                        r_state   <= (r_j == r_m - 1'b1) ? S_IDLE : S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pccp_ram #(.WIDTH(32), .DEPTH(pccp_pkg::COEF_SLOTS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_coef_index),
        .i_wdata (i_coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    pccp_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_view_ram (
        .i_clk   (i_clk),
        .i_we    (view_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (view_wdata),
        .i_raddr (view_raddr),
        .o_rdata (view_rdata)
    );

    pccp_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (clip_we),
        .i_waddr (r_m[AW-1:0]),
        .i_wdata (clip_wdata),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (clip_rdata)
    );

    pccp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    assign o_valid       = r_o_valid;
    assign o_screen_x    = r_o_sx;
    assign o_screen_y    = r_o_sy;
    assign o_point_index = r_o_idx;
    assign o_last_point  = r_o_last;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past capacity");

    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m <= CNT_W'(MAX_VERTICES))
        else $error("clipped point count past capacity");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_point) |=> !o_valid)
        else $error("result beat right after the last point");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule
